// ===== design/mdio_management_master_unit_assert.svh =====
// assertion macros shared by the mdio management master modules
`ifndef MDIO_MANAGEMENT_MASTER_UNIT_ASSERT_SVH
`define MDIO_MANAGEMENT_MASTER_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
`define MDIO_MM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define MDIO_MM_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`else
`define MDIO_MM_ASSERT(lbl, prop, msg)
`define MDIO_MM_ASSERT_IMP(lbl, ante, cons, msg)
`endif

`endif

// ===== design/mdio_mm_pkg.sv =====
// types, codes and constants of the mdio management master
package mdio_mm_pkg;

  localparam int PREAMBLE_LEN_DEF = 32;
  localparam int QUEUE_DEPTH_DEF  = 2;
  localparam int FRAME_BITS       = 32;
  localparam int DATA_BITS        = 16;

  // input opcodes
  localparam logic [1:0] OP_TICK  = 2'd0;
  localparam logic [1:0] OP_WRITE = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  // register selects
  localparam logic [2:0] SEL_COMMAND     = 3'd0;
  localparam logic [2:0] SEL_ADDRESS     = 3'd1;
  localparam logic [2:0] SEL_WRITE_DATA  = 3'd2;
  localparam logic [2:0] SEL_READ_STATUS = 3'd3;
  localparam logic [2:0] SEL_INDICATORS  = 3'd4;

  // indicator bits
  localparam int IND_BUSY_BIT      = 0;
  localparam int IND_NOT_VALID_BIT = 2;

  // configuration register index
  localparam logic REG_CLOCK_SELECT = 1'b0;
  localparam logic [2:0] CLOCK_SELECT_RESET = 3'd7;

  typedef enum logic [2:0] {
    CMD_TICK,
    CMD_WR_CMD,
    CMD_WR_ADDR,
    CMD_WR_DATA,
    CMD_READ,
    CMD_NOP
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t   kind;
    logic [2:0]  sel;
    logic [15:0] data;
    logic        mdio_in;
  } cmd_t;

  // ticks per mdc half period
  function automatic logic [4:0] half_period(input logic [2:0] sel);
    logic [4:0] hp;
    case (sel)
      3'd0:    hp = 5'd2;
      3'd1:    hp = 5'd2;
      3'd2:    hp = 5'd3;
      3'd3:    hp = 5'd4;
      3'd4:    hp = 5'd5;
      3'd5:    hp = 5'd7;
      3'd6:    hp = 5'd10;
      default: hp = 5'd14;
    endcase
    return hp;
  endfunction

endpackage

// ===== design/mdio_mm_front.sv =====
// front end: takes input transfers and decodes them into commands
module mdio_mm_front (
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [1:0]          in_opcode,
  input  logic [2:0]          in_reg_select,
  input  logic [15:0]         in_write_data,
  input  logic                in_mdio_in,
  input  logic                q_full,
  output logic                q_push,
  output mdio_mm_pkg::cmd_t   q_cmd
);
  import mdio_mm_pkg::*;

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;

  always_comb begin
    q_cmd.kind    = CMD_NOP;
    q_cmd.sel     = in_reg_select;
    q_cmd.data    = in_write_data;
    q_cmd.mdio_in = in_mdio_in;
    case (in_opcode)
      OP_TICK: q_cmd.kind = CMD_TICK;
      OP_WRITE: begin
        case (in_reg_select)
          SEL_COMMAND:    q_cmd.kind = CMD_WR_CMD;
          SEL_ADDRESS:    q_cmd.kind = CMD_WR_ADDR;
          SEL_WRITE_DATA: q_cmd.kind = CMD_WR_DATA;
          default:        q_cmd.kind = CMD_NOP;
        endcase
      end
      OP_READ: q_cmd.kind = CMD_READ;
      default: q_cmd.kind = CMD_NOP;
    endcase
  end

endmodule

// ===== design/mdio_mm_queue.sv =====
// short command queue between the front end and the frame engine
module mdio_mm_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] din,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] dout,
  output logic             not_empty
);
  `include "mdio_management_master_unit_assert.svh"

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [AW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;

  assign full      = (count_r == CW'(DEPTH));
  assign not_empty = (count_r != '0);
  assign dout      = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    case ({push, pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= din;
    end
  end

  `MDIO_MM_ASSERT(a_count_bound, count_r <= CW'(DEPTH), "queue count above depth")
  `MDIO_MM_ASSERT_IMP(a_no_pop_empty, pop, count_r != '0, "pop from empty queue")

endmodule

// ===== design/mdio_mm_back.sv =====
// frame engine: register file, mdc divider, frame shifter and result register
module mdio_mm_back #(
  parameter int PREAMBLE_LEN = mdio_mm_pkg::PREAMBLE_LEN_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [2:0]        clock_select,
  input  logic              q_not_empty,
  input  mdio_mm_pkg::cmd_t q_cmd,
  output logic              q_pop,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [15:0]       out_read_data,
  output logic              out_mdc,
  output logic              out_mdio_out,
  output logic              out_mdio_drive
);
  import mdio_mm_pkg::*;
  `include "mdio_management_master_unit_assert.svh"

  localparam logic [6:0] PRE       = 7'(PREAMBLE_LEN);
  localparam logic [6:0] DATA_POS  = 7'(PREAMBLE_LEN + DATA_BITS);
  localparam logic [6:0] FRAME_END = 7'(PREAMBLE_LEN + FRAME_BITS);

  logic [12:0] addr_r, addr_nxt;
  logic        read_cmd_r, read_cmd_nxt;
  logic [15:0] write_value_r, write_value_nxt;
  logic [15:0] read_value_r, read_value_nxt;
  logic        busy_r, busy_nxt;
  logic        not_valid_r, not_valid_nxt;
  logic [31:0] frame_shift_r, frame_shift_nxt;
  logic [6:0]  bit_pos_r, bit_pos_nxt;
  logic [4:0]  div_cnt_r, div_cnt_nxt;
  logic        clk_level_r, clk_level_nxt;
  logic        frame_is_read_r, frame_is_read_nxt;

  logic        out_valid_r;
  logic [15:0] out_read_data_r;
  logic        out_mdc_r, out_mdio_out_r, out_mdio_drive_r;

  logic [15:0] rd_data;
  logic        drv, dout;
  logic        start, start_read;
  logic [15:0] start_data;
  logic [4:0]  div_inc;
  logic [6:0]  bit_inc;
  logic [4:0]  k;

  assign q_pop = q_not_empty && (!out_valid_r || !out_stall);

  always_comb begin
    addr_nxt          = addr_r;
    read_cmd_nxt      = read_cmd_r;
    write_value_nxt   = write_value_r;
    read_value_nxt    = read_value_r;
    busy_nxt          = busy_r;
    not_valid_nxt     = not_valid_r;
    frame_shift_nxt   = frame_shift_r;
    bit_pos_nxt       = bit_pos_r;
    div_cnt_nxt       = div_cnt_r;
    clk_level_nxt     = clk_level_r;
    frame_is_read_nxt = frame_is_read_r;
    rd_data           = '0;
    start             = 1'b0;
    start_read        = 1'b0;
    start_data        = q_cmd.data;
    div_inc           = div_cnt_r + 5'd1;
    bit_inc           = bit_pos_r + 7'd1;
    if (q_pop) begin
      case (q_cmd.kind)
        CMD_TICK: begin
          if (busy_r) begin
            if (div_inc < half_period(clock_select)) begin
              div_cnt_nxt = div_inc;
            end else begin
              div_cnt_nxt = '0;
              if (!clk_level_r) begin
                // rising mdc edge: sample data bits of a read
                clk_level_nxt = 1'b1;
                if (frame_is_read_r && bit_pos_r >= DATA_POS) begin
                  read_value_nxt = {read_value_r[14:0], q_cmd.mdio_in};
                end
              end else begin
                clk_level_nxt = 1'b0;
                if (bit_inc >= FRAME_END) begin
                  busy_nxt    = 1'b0;
                  bit_pos_nxt = '0;
                  if (frame_is_read_r) begin
                    not_valid_nxt = 1'b0;
                  end
                end else begin
                  bit_pos_nxt = bit_inc;
                end
              end
            end
          end
        end
        CMD_WR_CMD: begin
          if (!busy_r) begin
            read_cmd_nxt = q_cmd.data[0];
            if (!read_cmd_r && q_cmd.data[0]) begin
              start      = 1'b1;
              start_read = 1'b1;
            end
          end
        end
        CMD_WR_ADDR: begin
          if (!busy_r) begin
            addr_nxt = {q_cmd.data[12:8], 3'b000, q_cmd.data[4:0]};
          end
        end
        CMD_WR_DATA: begin
          if (!busy_r) begin
            write_value_nxt = q_cmd.data;
            start           = 1'b1;
          end
        end
        CMD_READ: begin
          case (q_cmd.sel)
            SEL_COMMAND:     rd_data = {15'd0, read_cmd_r};
            SEL_ADDRESS:     rd_data = {3'd0, addr_r};
            SEL_WRITE_DATA:  rd_data = write_value_r;
            SEL_READ_STATUS: rd_data = read_value_r;
            SEL_INDICATORS: begin
              rd_data[IND_BUSY_BIT]      = busy_r;
              rd_data[IND_NOT_VALID_BIT] = not_valid_r;
            end
            default:         rd_data = '0;
          endcase
        end
        default: begin
        end
      endcase
      if (start) begin
        // start 01, opcode, phy, register, turnaround, data
        frame_shift_nxt = {2'b01, start_read ? 2'b10 : 2'b01, addr_r[12:8], addr_r[4:0],
                           start_read ? 2'b00 : 2'b10, start_read ? 16'd0 : start_data};
        frame_is_read_nxt = start_read;
        busy_nxt          = 1'b1;
        bit_pos_nxt       = '0;
        div_cnt_nxt       = '0;
        clk_level_nxt     = 1'b0;
        if (start_read) begin
          not_valid_nxt = 1'b1;
        end
      end
    end
  end

  // mdio line from the state after this transfer
  always_comb begin
    drv  = 1'b0;
    dout = 1'b0;
    k    = 5'(bit_pos_nxt - PRE);
    if (busy_nxt) begin
      if (bit_pos_nxt < PRE) begin
        drv  = 1'b1;
        dout = 1'b1;
      end else if (!(frame_is_read_nxt && k >= 5'd14)) begin
        drv  = 1'b1;
        dout = frame_shift_nxt[~k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      addr_r          <= '0;
      read_cmd_r      <= 1'b0;
      write_value_r   <= '0;
      read_value_r    <= '0;
      busy_r          <= 1'b0;
      not_valid_r     <= 1'b0;
      frame_shift_r   <= '0;
      bit_pos_r       <= '0;
      div_cnt_r       <= '0;
      clk_level_r     <= 1'b0;
      frame_is_read_r <= 1'b0;
      out_valid_r     <= 1'b0;
    end else begin
      addr_r          <= addr_nxt;
      read_cmd_r      <= read_cmd_nxt;
      write_value_r   <= write_value_nxt;
      read_value_r    <= read_value_nxt;
      busy_r          <= busy_nxt;
      not_valid_r     <= not_valid_nxt;
      frame_shift_r   <= frame_shift_nxt;
      bit_pos_r       <= bit_pos_nxt;
      div_cnt_r       <= div_cnt_nxt;
      clk_level_r     <= clk_level_nxt;
      frame_is_read_r <= frame_is_read_nxt;
      if (q_pop) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      out_read_data_r  <= rd_data;
      out_mdc_r        <= clk_level_nxt;
      out_mdio_out_r   <= dout;
      out_mdio_drive_r <= drv;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_read_data  = out_read_data_r;
  assign out_mdc        = out_mdc_r;
  assign out_mdio_out   = out_mdio_out_r;
  assign out_mdio_drive = out_mdio_drive_r;

  `MDIO_MM_ASSERT_IMP(a_idle_mdc_low, !busy_r, !clk_level_r, "mdc high while idle")
  `MDIO_MM_ASSERT_IMP(a_not_valid_busy, not_valid_r, busy_r, "not-valid without busy")
  `MDIO_MM_ASSERT(a_bit_pos_range, bit_pos_r < FRAME_END, "bit position past frame end")

endmodule

// ===== design/mdio_management_master_unit.sv =====
// top level of the mdio management master: config register, front end, queue, frame engine
//
// Clause-22 MDIO master driven by a stream of bus accesses and clock ticks. Every input
// transfer gives exactly one result transfer: read data (zero on writes and ticks) plus the
// mdc, mdio_out and mdio_drive levels after that item. One item is taken per clock cycle
// when the result side keeps up; the decoded command passes a two-entry queue and the frame
// engine updates its state and registers the result when it pops the command. The mdc
// divider is picked by clock_select at byte address 0 of the config
// port (divide by 4,4,6,8,10,14,20,28 ticks, reset 7); write it only while no frame runs.
module mdio_management_master_unit #(
  parameter int PREAMBLE_LEN = mdio_mm_pkg::PREAMBLE_LEN_DEF,
  parameter int QUEUE_DEPTH  = mdio_mm_pkg::QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_opcode,
  input  logic [2:0]  in_reg_select,
  input  logic [15:0] in_write_data,
  input  logic        in_mdio_in,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] out_read_data,
  output logic        out_mdc,
  output logic        out_mdio_out,
  output logic        out_mdio_drive,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import mdio_mm_pkg::*;

  localparam int CMD_W = $bits(cmd_t);

  logic [2:0]       clock_select_r;
  logic             q_full, q_push, q_pop, q_not_empty;
  cmd_t             push_cmd;
  logic [CMD_W-1:0] pop_bits;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_CLOCK_SELECT) ? {29'd0, clock_select_r} : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clock_select_r <= CLOCK_SELECT_RESET;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_CLOCK_SELECT) begin
      clock_select_r <= pwdata[2:0];
    end
  end

  mdio_mm_front u_front (
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_opcode     (in_opcode),
    .in_reg_select (in_reg_select),
    .in_write_data (in_write_data),
    .in_mdio_in    (in_mdio_in),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_cmd         (push_cmd)
  );

  mdio_mm_queue #(
    .WIDTH (CMD_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .din       (push_cmd),
    .full      (q_full),
    .pop       (q_pop),
    .dout      (pop_bits),
    .not_empty (q_not_empty)
  );

  mdio_mm_back #(
    .PREAMBLE_LEN (PREAMBLE_LEN)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .clock_select   (clock_select_r),
    .q_not_empty    (q_not_empty),
    .q_cmd          (cmd_t'(pop_bits)),
    .q_pop          (q_pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_read_data  (out_read_data),
    .out_mdc        (out_mdc),
    .out_mdio_out   (out_mdio_out),
    .out_mdio_drive (out_mdio_drive)
  );

endmodule

// ===== tb/mdio_management_master_unit_tb.sv =====
// self-checking testbench for the mdio management master: directed table, then random frames
module mdio_management_master_unit_tb;
  import mdio_mm_pkg::*;

  localparam int PREAMBLE      = 32;
  localparam int PHASE_ITEMS   = 170;
  localparam int CYCLE_LIMIT   = 500000;
  localparam int MAX_REPORTS   = 200;
  localparam int SETTLE_CYCLES = 2;
  localparam int TAIL_CYCLES   = 8;

  localparam logic [1:0] OP_UNUSED  = 2'd3;
  localparam logic [2:0] SEL_SPARE0 = 3'd5;
  localparam logic [2:0] SEL_SPARE1 = 3'd6;
  localparam logic [2:0] SEL_SPARE2 = 3'd7;
  localparam logic [2:0] CLK_SEL_ADDR = 3'(4 * REG_CLOCK_SELECT);

  // mdc half period in ticks, 5 bits per clock select, select 0 at the bottom
  localparam logic [39:0] MDC_HALF_TABLE =
    {5'd14, 5'd10, 5'd7, 5'd5, 5'd4, 5'd3, 5'd2, 5'd2};

  typedef struct packed {
    logic [15:0] read_data;
    logic        mdc;
    logic        mdio_out;
    logic        mdio_drive;
  } mdio_result_t;

  typedef struct packed {
    logic [1:0]  op;
    logic [2:0]  sel;
    logic [15:0] data;
    logic        din;
    logic        typed;
    logic [15:0] rd;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  in_opcode = OP_TICK;
  logic [2:0]  in_reg_select = SEL_COMMAND;
  logic [15:0] in_write_data = 16'h0000;
  logic        in_mdio_in = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [15:0] out_read_data;
  logic        out_mdc;
  logic        out_mdio_out;
  logic        out_mdio_drive;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = 3'd0;
  logic [31:0] pwdata = 32'd0;
  logic [31:0] prdata;
  logic        pready;

  mdio_management_master_unit #(
    .PREAMBLE_LEN(PREAMBLE)
  ) dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_opcode(in_opcode),
    .in_reg_select(in_reg_select), .in_write_data(in_write_data), .in_mdio_in(in_mdio_in),
    .out_valid(out_valid), .out_stall(out_stall), .out_read_data(out_read_data),
    .out_mdc(out_mdc), .out_mdio_out(out_mdio_out), .out_mdio_drive(out_mdio_drive),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // mirror of the block state
  logic [2:0]  mm_clk_sel = CLOCK_SELECT_RESET;
  logic [12:0] mm_addr = '0;
  logic        mm_cmd = 1'b0;
  logic [15:0] mm_wval = '0;
  logic [15:0] mm_rval = '0;
  logic        mm_busy = 1'b0;
  logic        mm_not_valid = 1'b0;
  logic [31:0] mm_frame = '0;
  logic [6:0]  mm_bitpos = '0;
  logic [4:0]  mm_div = '0;
  logic        mm_mdc = 1'b0;
  logic        mm_is_read = 1'b0;

  mdio_result_t mdio_results_due[$];
  mdio_result_t due_res, seen_res;
  int fault_count = 0;
  int cycle_count = 0;
  int items_sent = 0;
  int phase_start = 0;
  int rx_wait = 0;
  bit calm = 1'b0;
  logic        pin_en = 1'b0;
  logic [15:0] pin_rd = '0;

  function automatic void launch_frame(input logic is_read);
    logic [31:0] f;
    f = 32'h4000_0000 | (32'(mm_addr[12:8]) << 23) | (32'(mm_addr[4:0]) << 18);
    if (is_read) begin
      f = f | (32'h2 << 28);
      mm_not_valid = 1'b1;
    end else begin
      f = f | (32'h1 << 28) | (32'h2 << 16) | 32'(mm_wval);
    end
    mm_frame = f;
    mm_is_read = is_read;
    mm_busy = 1'b1;
    mm_bitpos = '0;
    mm_div = '0;
    mm_mdc = 1'b0;
  endfunction

  function automatic void mdc_tick(input logic din);
    if (!mm_busy) return;
    mm_div = mm_div + 5'd1;
    if (mm_div < MDC_HALF_TABLE[mm_clk_sel * 5 +: 5]) return;
    mm_div = '0;
    if (!mm_mdc) begin
      mm_mdc = 1'b1;
      // read data is captured on rising mdc during the data bits
      if (mm_is_read && mm_bitpos >= PREAMBLE + DATA_BITS)
        mm_rval = {mm_rval[14:0], din};
    end else begin
      mm_mdc = 1'b0;
      mm_bitpos = mm_bitpos + 7'd1;
      if (mm_bitpos >= PREAMBLE + FRAME_BITS) begin
        mm_busy = 1'b0;
        if (mm_is_read) mm_not_valid = 1'b0;
        mm_bitpos = '0;
      end
    end
  endfunction

  function automatic mdio_result_t predict_mdio_item(input logic [1:0] op,
      input logic [2:0] sel, input logic [15:0] data, input logic din);
    mdio_result_t res;
    logic [4:0] k;
    res = '0;
    case (op)
      OP_TICK: mdc_tick(din);
      OP_WRITE: begin
        if (!mm_busy) begin
          if (sel == SEL_COMMAND) begin
            if (!mm_cmd && data[0]) begin
              mm_cmd = 1'b1;
              launch_frame(1'b1);
            end else begin
              mm_cmd = data[0];
            end
          end else if (sel == SEL_ADDRESS) begin
            mm_addr = data[12:0] & 13'h1f1f;
          end else if (sel == SEL_WRITE_DATA) begin
            mm_wval = data;
            launch_frame(1'b0);
          end
        end
      end
      OP_READ: begin
        case (sel)
          SEL_COMMAND:     res.read_data = {15'd0, mm_cmd};
          SEL_ADDRESS:     res.read_data = {3'd0, mm_addr};
          SEL_WRITE_DATA:  res.read_data = mm_wval;
          SEL_READ_STATUS: res.read_data = mm_rval;
          SEL_INDICATORS: begin
            res.read_data[IND_BUSY_BIT] = mm_busy;
            res.read_data[IND_NOT_VALID_BIT] = mm_not_valid;
          end
          default: res.read_data = '0;
        endcase
      end
      default: ;
    endcase
    if (mm_busy) begin
      if (mm_bitpos < PREAMBLE) begin
        res.mdio_drive = 1'b1;
        res.mdio_out = 1'b1;
      end else begin
        k = 5'(mm_bitpos - PREAMBLE);
        // turnaround and data of a read leave mdio released
        if (!(mm_is_read && k >= 5'd14)) begin
          res.mdio_drive = 1'b1;
          res.mdio_out = mm_frame[31 - k];
        end
      end
    end
    res.mdc = mm_mdc;
    return res;
  endfunction

  task automatic report_diff(input string what, input logic [31:0] want, input logic [31:0] got);
    fault_count++;
    if (fault_count <= MAX_REPORTS)
      $display("%0t %s mismatch: expected %h, actual %h", $time, what, want, got);
  endtask

  // input and result transfers seen at the same edge
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) begin
      due_res = predict_mdio_item(in_opcode, in_reg_select, in_write_data, in_mdio_in);
      if (pin_en) due_res.read_data = pin_rd;
      mdio_results_due.push_back(due_res);
    end
    if (rst_n && out_valid && !out_stall) begin
      seen_res = '{out_read_data, out_mdc, out_mdio_out, out_mdio_drive};
      if (mdio_results_due.size() == 0) begin
        report_diff("unexpected result transfer", 32'd0, 32'(seen_res));
      end else begin
        due_res = mdio_results_due.pop_front();
        if (seen_res.read_data !== due_res.read_data)
          report_diff("read_data", 32'(due_res.read_data), 32'(seen_res.read_data));
        if (seen_res.mdc !== due_res.mdc)
          report_diff("mdc", 32'(due_res.mdc), 32'(seen_res.mdc));
        if (seen_res.mdio_out !== due_res.mdio_out)
          report_diff("mdio_out", 32'(due_res.mdio_out), 32'(seen_res.mdio_out));
        if (seen_res.mdio_drive !== due_res.mdio_drive)
          report_diff("mdio_drive", 32'(due_res.mdio_drive), 32'(seen_res.mdio_drive));
      end
      rx_wait = calm ? 0 : $urandom_range(0, 11);
    end
  end

  always @(negedge clk) begin
    if (rst_n && rx_wait > 0) begin
      out_stall <= 1'b1;
      rx_wait = rx_wait - 1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // called at a falling edge, returns at the falling edge after the transfer
  task automatic send_item(input logic [1:0] op, input logic [2:0] sel,
      input logic [15:0] data, input logic din);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_opcode <= op;
    in_reg_select <= sel;
    in_write_data <= data;
    in_mdio_in <= din;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    items_sent++;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (mdio_results_due.size() > 0) @(negedge clk);
  endtask

  task automatic set_clock_select(input logic [2:0] sel_val);
    wait_drained();
    repeat (SETTLE_CYCLES) @(negedge clk);
    // read back the current value, then write the new one
    psel <= 1'b1;
    pwrite <= 1'b0;
    penable <= 1'b0;
    paddr <= CLK_SEL_ADDR;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== {29'd0, mm_clk_sel})
      report_diff("clock_select readback", {29'd0, mm_clk_sel}, prdata);
    @(negedge clk);
    penable <= 1'b0;
    pwrite <= 1'b1;
    pwdata <= {29'd0, sel_val};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    mm_clk_sel = sel_val;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic send_random_item();
    send_item(2'($urandom_range(0, 3)), 3'($urandom_range(0, 7)), 16'($urandom),
              1'($urandom));
  endtask

  task automatic frame_body_item();
    int r;
    if ($urandom_range(0, 299) == 0) wait_drained();
    r = $urandom_range(0, 99);
    if (r < 85)
      send_item(OP_TICK, 3'($urandom_range(0, 7)), 16'($urandom), 1'($urandom));
    else if (r < 93)
      send_item(OP_READ, 3'($urandom_range(0, 7)), 16'($urandom), 1'($urandom));
    else if (r < 98)
      send_item(OP_WRITE, 3'($urandom_range(0, 7)), 16'($urandom), 1'($urandom));
    else
      send_item(OP_UNUSED, 3'($urandom_range(0, 7)), 16'($urandom), 1'($urandom));
  endtask

  // one management transaction: set up, start a write or read frame or send random items, then
  // send mostly ticks until the frame ends or the phase runs out of items
  task automatic run_sequence(input bit force_read);
    int kind;
    kind = force_read ? 5 : $urandom_range(0, 9);
    calm = ($urandom_range(0, 3) == 0);
    if (kind < 8 && $urandom_range(0, 1))
      send_item(OP_WRITE, SEL_ADDRESS, 16'($urandom), 1'($urandom));
    if (kind < 4) begin
      send_item(OP_WRITE, SEL_WRITE_DATA, 16'($urandom), 1'($urandom));
    end else if (kind < 8) begin
      // a read frame needs command bit 0 going from low to high
      if (mm_cmd)
        send_item(OP_WRITE, SEL_COMMAND, {15'($urandom), 1'b0}, 1'($urandom));
      send_item(OP_WRITE, SEL_COMMAND, {15'($urandom), 1'b1}, 1'($urandom));
    end else begin
      repeat ($urandom_range(3, 12)) send_random_item();
    end
    while (mm_busy && items_sent - phase_start < PHASE_ITEMS) frame_body_item();
    calm = 1'b0;
  endtask

  stim_row_t directed_rows [23];
  logic [2:0] phase_sel [5];

  initial begin
    directed_rows = '{
      '{OP_READ,   SEL_COMMAND,     16'h0000, 1'b0, 1'b1, 16'h0000},
      '{OP_READ,   SEL_ADDRESS,     16'h0000, 1'b0, 1'b1, 16'h0000},
      '{OP_READ,   SEL_WRITE_DATA,  16'h0000, 1'b0, 1'b1, 16'h0000},
      '{OP_READ,   SEL_READ_STATUS, 16'h0000, 1'b0, 1'b1, 16'h0000},
      '{OP_READ,   SEL_INDICATORS,  16'h0000, 1'b0, 1'b1, 16'h0000},
      '{OP_READ,   SEL_SPARE0,      16'h0000, 1'b0, 1'b1, 16'h0000},
      '{OP_READ,   SEL_SPARE1,      16'h0000, 1'b0, 1'b1, 16'h0000},
      '{OP_READ,   SEL_SPARE2,      16'hffff, 1'b1, 1'b1, 16'h0000},
      '{OP_UNUSED, SEL_WRITE_DATA,  16'hffff, 1'b1, 1'b1, 16'h0000},
      '{OP_TICK,   SEL_COMMAND,     16'hffff, 1'b1, 1'b1, 16'h0000},
      '{OP_WRITE,  SEL_ADDRESS,     16'hffff, 1'b0, 1'b1, 16'h0000},
      '{OP_READ,   SEL_ADDRESS,     16'h0000, 1'b0, 1'b1, 16'h1f1f},
      '{OP_WRITE,  SEL_READ_STATUS, 16'hffff, 1'b0, 1'b1, 16'h0000},
      '{OP_WRITE,  SEL_INDICATORS,  16'hffff, 1'b0, 1'b1, 16'h0000},
      '{OP_WRITE,  SEL_SPARE2,      16'hffff, 1'b0, 1'b1, 16'h0000},
      '{OP_READ,   SEL_READ_STATUS, 16'h0000, 1'b0, 1'b1, 16'h0000},
      '{OP_READ,   SEL_INDICATORS,  16'h0000, 1'b0, 1'b1, 16'h0000},
      '{OP_WRITE,  SEL_COMMAND,     16'hfffe, 1'b0, 1'b1, 16'h0000},
      '{OP_READ,   SEL_COMMAND,     16'h0000, 1'b0, 1'b1, 16'h0000},
      '{OP_WRITE,  SEL_ADDRESS,     16'ha0b5, 1'b1, 1'b0, 16'h0000},
      '{OP_READ,   SEL_ADDRESS,     16'h0000, 1'b0, 1'b0, 16'h0000},
      '{OP_UNUSED, SEL_SPARE1,      16'h0000, 1'b0, 1'b1, 16'h0000},
      '{OP_READ,   SEL_SPARE1,      16'hffff, 1'b1, 1'b1, 16'h0000}
    };
    // slowest divider last, with a read frame attempt
    phase_sel = '{3'd0, 3'd2, 3'd1, 3'd0, 3'd7};

    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (directed_rows[i]) begin
      pin_en = directed_rows[i].typed;
      pin_rd = directed_rows[i].rd;
      send_item(directed_rows[i].op, directed_rows[i].sel, directed_rows[i].data,
                directed_rows[i].din);
    end
    pin_en = 1'b0;

    foreach (phase_sel[p]) begin
      set_clock_select(phase_sel[p]);
      phase_start = items_sent;
      if (phase_sel[p] == 3'd7) begin
        run_sequence(1'b1);
      end else begin
        while (items_sent - phase_start < PHASE_ITEMS) run_sequence(1'b0);
      end
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fault_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+design
design/mdio_mm_pkg.sv
design/mdio_mm_front.sv
design/mdio_mm_queue.sv
design/mdio_mm_back.sv
design/mdio_management_master_unit.sv
tb/mdio_management_master_unit_tb.sv
